// ===== src/tws_pkg.sv =====
// shared types and constants of the timing wheel event scheduler
`timescale 1ns / 1ps

package tws_pkg;

    // default wheel geometry
    localparam int WHEEL_SLOTS_DEF  = 8;
    localparam int BUCKET_DEPTH_DEF = 8;

    // most fired results given for one process command
    localparam int MAX_RESULTS = 8;

    // command codes
    localparam logic ACT_ADD     = 1'b0;
    localparam logic ACT_PROCESS = 1'b1;

    // result status codes
    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_DROPPED  = 2'd1;
    localparam logic [1:0] ST_FIRED    = 2'd2;

    // input command
    typedef struct packed {
        logic        action;
        logic [31:0] tick_time;
        logic [15:0] event_id;
    } t_item;

    // one result
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] fired_id;
        logic [31:0] fired_time;
        logic        last;
    } t_result;

    // one stored wheel entry
    typedef struct packed {
        logic [31:0] due;
        logic [15:0] id;
    } t_entry;

endpackage

// ===== src/tws_ram.sv =====
// generic single write port ram with one registered read port
`timescale 1ns / 1ps

module tws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/timer_wheel_event_scheduler.sv =====
// top level of the hashed timing wheel event scheduler
`timescale 1ns / 1ps

// Usage: a command on i_item is taken at a rising edge with start high and
// busy low. An add command (action 0) stores (tick_time, event_id) in slot
// tick_time mod WHEEL_SLOTS and gives one result, accepted or dropped when
// the slot already holds BUCKET_DEPTH entries. A process command (action 1)
// pops entries from the front of slot tick_time mod WHEEL_SLOTS while the
// front entry is due, at most eight, and gives one fired result per pop;
// nothing due gives no result. Each result shows on o_result for one cycle
// with o_result_strobe high, and o_result.last marks the final result of a
// command. The receiver cannot stall; results come at most one per cycle.
// Timing: with a power-of-two WHEEL_SLOTS the slot is the low time bits;
// otherwise a reciprocal multiply and then a subtract find it. Then the slot
// pointer ram is read. An add then writes its entry and registers an
// accepted result; a full slot gives its dropped result from the slot
// pointer read. Each pop is an entry ram read, then a compare against the
// current time; the final result comes from a flush state after the last
// pop, or from the compare that finds a front entry not yet due. Busy drops
// in the cycle the final result shows; an empty slot frees the block as soon
// as the slot pointers are read. After reset a clearing pass zeroes them all.

module timer_wheel_event_scheduler
    import tws_pkg::*;
#(
    parameter int WHEEL_SLOTS  = WHEEL_SLOTS_DEF,
    parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output t_result o_result,
    output logic    o_result_strobe
);

    localparam int  SLOT_W  = $clog2(WHEEL_SLOTS);
    localparam int  ENTRIES = WHEEL_SLOTS * BUCKET_DEPTH;
    localparam int  ADDR_W  = $clog2(ENTRIES);
    localparam int  HEAD_W  = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int  CNT_W   = $clog2(BUCKET_DEPTH + 1);
    localparam int  SUM_W   = CNT_W + 1;
    localparam int  META_W  = HEAD_W + CNT_W;
    localparam int  NF_W    = $clog2(MAX_RESULTS + 1);
    localparam int  ENT_W   = $bits(t_entry);
    localparam bit  IS_POW2 = (WHEEL_SLOTS & (WHEEL_SLOTS - 1)) == 0;
    // reciprocal of the slot count, rounded up, exact for any 32-bit time
    localparam int  MOD_SH  = 32 + SLOT_W;
    localparam logic [32:0] RECIP = 33'(((64'd1 << MOD_SH) + 64'(WHEEL_SLOTS) - 64'd1)
                                        / 64'(WHEEL_SLOTS));

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_MOD_SUB,
        S_META_RD,
        S_META,
        S_ADD_WR,
        S_POP_RD,
        S_POP_CHK,
        S_FLUSH
    } t_state;

    t_state              r_state, n_state;
    t_item               r_item, n_item;
    logic [SLOT_W-1:0]   r_clr, n_clr;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [SLOT_W-1:0]   r_quo, n_quo;
    logic [ADDR_W-1:0]   r_base, n_base;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [HEAD_W-1:0]   r_head, n_head;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [NF_W-1:0]     r_nfire, n_nfire;
    t_entry              r_pend, n_pend;
    logic                r_pend_v, n_pend_v;
    t_result             r_res, n_res;
    logic                r_res_v, n_res_v;

    // ram control
    logic                meta_we;
    logic [SLOT_W-1:0]   meta_waddr;
    logic [META_W-1:0]   meta_wdata;
    logic [META_W-1:0]   meta_rdata;
    logic                ent_we;
    logic [ENT_W-1:0]    ent_rdata;
    t_entry              ent_new;
    t_entry              ent_rd;

    // helper values
    logic [64:0]         mod_prod;
    logic [SLOT_W-1:0]   mod_qm;
    logic [HEAD_W-1:0]   meta_head;
    logic [CNT_W-1:0]    meta_count;
    logic [SUM_W-1:0]    pos_sum;
    logic [HEAD_W-1:0]   pos_wr;
    logic [HEAD_W-1:0]   head_inc;
    logic                due_now;

    // slot pointer ram: head and fill count per slot
    tws_ram #(
        .WIDTH (META_W),
        .DEPTH (WHEEL_SLOTS)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_raddr (r_slot),
        .o_rdata (meta_rdata)
    );

    // entry ram: due time and id, one bucket per slot
    tws_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (r_addr),
        .i_wdata (ent_new),
        .i_raddr (r_addr),
        .o_rdata (ent_rdata)
    );

    assign ent_new.due = r_item.tick_time;
    assign ent_new.id  = r_item.event_id;
    assign ent_rd      = t_entry'(ent_rdata);
    assign meta_head   = meta_rdata[META_W-1:CNT_W];
    assign meta_count  = meta_rdata[CNT_W-1:0];

    // quotient by reciprocal multiply, then low bits of quotient times slot count
    assign mod_prod = {33'd0, r_item.tick_time} * {32'd0, RECIP};
    assign mod_qm   = r_quo * SLOT_W'(WHEEL_SLOTS);

    // write position of an add, wrapped inside the bucket
    always_comb begin
        pos_sum = SUM_W'(meta_head) + SUM_W'(meta_count);
        if (pos_sum >= SUM_W'(BUCKET_DEPTH)) begin
            pos_sum = pos_sum - SUM_W'(BUCKET_DEPTH);
        end
        pos_wr = pos_sum[HEAD_W-1:0];
    end

    // head after one pop
    assign head_inc = (r_head == HEAD_W'(BUCKET_DEPTH - 1)) ? '0 : r_head + 1'b1;

    // front entry due at the current time
    assign due_now = ent_rd.due <= r_item.tick_time;

    // sequencer next state
    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_clr      = r_clr;
        n_slot     = r_slot;
        n_quo      = r_quo;
        n_base     = r_base;
        n_addr     = r_addr;
        n_head     = r_head;
        n_count    = r_count;
        n_nfire    = r_nfire;
        n_pend     = r_pend;
        n_pend_v   = r_pend_v;
        n_res      = r_res;
        n_res_v    = 1'b0;
        meta_we    = 1'b0;
        meta_waddr = r_slot;
        meta_wdata = {r_head, r_count};
        ent_we     = 1'b0;

        case (r_state)
            // zero the slot pointers after reset
            S_CLEAR: begin
                meta_we    = 1'b1;
                meta_waddr = r_clr;
                meta_wdata = '0;
                n_clr      = r_clr + 1'b1;
                if (r_clr == SLOT_W'(WHEEL_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end

            // take a command
            S_IDLE: begin
                if (start) begin
                    n_item = i_item;
                    if (IS_POW2) begin
                        n_slot  = i_item.tick_time[SLOT_W-1:0];
                        n_state = S_META_RD;
                    end else begin
                        n_state = S_MOD;
                    end
                end
            end

            // quotient of the time by the slot count
            S_MOD: begin
                n_quo   = mod_prod[MOD_SH +: SLOT_W];
                n_state = S_MOD_SUB;
            end

            // remainder from the low bits of time and quotient product
            S_MOD_SUB: begin
                n_slot  = r_item.tick_time[SLOT_W-1:0] - mod_qm;
                n_state = S_META_RD;
            end

            // slot pointer read in flight, bucket base address
            S_META_RD: begin
                n_base  = ADDR_W'(r_slot) * ADDR_W'(BUCKET_DEPTH);
                n_state = S_META;
            end

            // slot pointers available
            S_META: begin
                n_head  = meta_head;
                n_count = meta_count;
                if (r_item.action == ACT_ADD) begin
                    if (meta_count >= CNT_W'(BUCKET_DEPTH)) begin
                        n_res.status     = ST_DROPPED;
                        n_res.fired_id   = r_item.event_id;
                        n_res.fired_time = r_item.tick_time;
                        n_res.last       = 1'b1;
                        n_res_v          = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        n_addr  = r_base + ADDR_W'(pos_wr);
                        n_state = S_ADD_WR;
                    end
                end else begin
                    if (meta_count == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_addr   = r_base + ADDR_W'(meta_head);
                        n_nfire  = '0;
                        n_pend_v = 1'b0;
                        n_state  = S_POP_RD;
                    end
                end
            end

            // store the new entry and bump the fill count
            S_ADD_WR: begin
                ent_we           = 1'b1;
                meta_we          = 1'b1;
                meta_wdata       = {r_head, r_count + 1'b1};
                n_res.status     = ST_ACCEPTED;
                n_res.fired_id   = r_item.event_id;
                n_res.fired_time = r_item.tick_time;
                n_res.last       = 1'b1;
                n_res_v          = 1'b1;
                n_state          = S_IDLE;
            end

            // front entry read in flight
            S_POP_RD: begin
                n_state = S_POP_CHK;
            end

            // pop the front entry if due; a fired entry is held as pending so
            // that its last flag is known when it goes out
            S_POP_CHK: begin
                if (due_now) begin
                    if (r_pend_v) begin
                        n_res.status     = ST_FIRED;
                        n_res.fired_id   = r_pend.id;
                        n_res.fired_time = r_pend.due;
                        n_res.last       = 1'b0;
                        n_res_v          = 1'b1;
                    end
                    n_pend   = ent_rd;
                    n_pend_v = 1'b1;
                    n_head   = head_inc;
                    n_count  = r_count - 1'b1;
                    n_nfire  = r_nfire + 1'b1;
                    if (r_nfire == NF_W'(MAX_RESULTS - 1) || r_count == CNT_W'(1)) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_addr  = r_base + ADDR_W'(head_inc);
                        n_state = S_POP_RD;
                    end
                end else begin
                    if (r_pend_v) begin
                        n_res.status     = ST_FIRED;
                        n_res.fired_id   = r_pend.id;
                        n_res.fired_time = r_pend.due;
                        n_res.last       = 1'b1;
                        n_res_v          = 1'b1;
                    end
                    n_pend_v = 1'b0;
                    meta_we  = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            // hand out the final fired entry and save the slot pointers
            S_FLUSH: begin
                n_res.status     = ST_FIRED;
                n_res.fired_id   = r_pend.id;
                n_res.fired_time = r_pend.due;
                n_res.last       = 1'b1;
                n_res_v          = 1'b1;
                n_pend_v         = 1'b0;
                meta_we          = 1'b1;
                n_state          = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_pend_v <= 1'b0;
            r_res_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_pend_v <= n_pend_v;
            r_res_v  <= n_res_v;
        end
        r_item  <= n_item;
        r_slot  <= n_slot;
        r_quo   <= n_quo;
        r_base  <= n_base;
        r_addr  <= n_addr;
        r_head  <= n_head;
        r_count <= n_count;
        r_nfire <= n_nfire;
        r_pend  <= n_pend;
        r_res   <= n_res;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_result        = r_res;
    assign o_result_strobe = r_res_v;

endmodule
